[src/assert_macros.svh]
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

[src/atan2ro_pkg.sv]
package atan2ro_pkg;

    // Octant ratio is unsigned Q1.16 and may reach exactly 1.0.
    localparam int R_FRAC  = 16;
    localparam int R_WIDTH = R_FRAC + 1;
    // Polynomial terms stay below 2^17; one spare bit.
    localparam int P_WIDTH = 18;

    // Rational approximation coefficients, Q2.16.
    localparam logic [P_WIDTH-1:0] C_N1 = 18'd0;
    localparam logic [P_WIDTH-1:0] C_N2 = 18'd65534;
    localparam logic [P_WIDTH-1:0] C_N3 = 18'd9663;
    localparam logic [P_WIDTH-1:0] C_N4 = 18'd20315;
    localparam logic [P_WIDTH-1:0] C_N5 = 18'd3297;
    localparam logic [P_WIDTH-1:0] C_D1 = 18'd9641;
    localparam logic [P_WIDTH-1:0] C_D2 = 18'd42236;
    localparam logic [P_WIDTH-1:0] C_ONE = 18'd65536;

    // pi in Q29.
    localparam logic [63:0] PI_Q29 = 64'd1686629713;

    typedef struct packed {
        logic ygtx;
        logic xneg;
        logic yneg;
    } t_quad;

    // Q16 product with round half up.
    function automatic logic [P_WIDTH-1:0] mul_q16(input logic [P_WIDTH-1:0] a,
                                                   input logic [R_WIDTH-1:0] r);
        logic [P_WIDTH+R_WIDTH-1:0] p;
        p = {{R_WIDTH{1'b0}}, a} * {{P_WIDTH{1'b0}}, r};
        p = p + (P_WIDTH+R_WIDTH)'(32768);
        return p[R_FRAC +: P_WIDTH];
    endfunction

endpackage

[src/atan2_rational_octant.sv]
// Four-quadrant arctangent: each word (y, x) gives angle = atan2(y, x) in signed
// Q2.ANGLE_FRAC_BITS radians, from -pi to pi, with (0, 0) giving 0 and y = 0 with
// negative x giving +pi. A new word is taken every clock cycle while o_in_stall is low.
// The word passes ANGLE_FRAC_BITS + 25 register stages before its result shows on
// o_out_valid, and the edge that accepts the word already loads the first of them.
// The stages are set by the two bit-per-stage restoring dividers: 17 stages for the
// Q1.16 octant ratio and ANGLE_FRAC_BITS + 1 stages for the final numerator over
// denominator quotient, plus one stage of magnitude sorting, four polynomial stages,
// one dividend stage and the output register. A two-entry output buffer lets the
// block keep taking words while a result waits; the input stalls only once the
// spare entry is occupied.
`include "assert_macros.svh"

module atan2_rational_octant
    import atan2ro_pkg::*;
#(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [COORD_WIDTH-1:0]       i_y_coord,
    input  logic [COORD_WIDTH-1:0]       i_x_coord,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ANGLE_FRAC_BITS+2:0]   o_angle
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = ANGLE_FRAC_BITS;
    localparam int AW  = F + 3;
    localparam int DVW = P_WIDTH + F + 1;     // rounded dividend width
    localparam int QW  = F + 1;               // final quotient width
    localparam int SH  = 29 - F;

    // Stage map: magnitude sort, ratio divider, polynomial, dividend, quotient.
    localparam int ST_D1 = 1;
    localparam int ST_P  = ST_D1 + R_WIDTH;
    localparam int ST_DF = ST_P + 4;
    localparam int ST_D2 = ST_DF + 1;
    localparam int NP    = ST_D2 + QW;

    localparam logic [63:0] PI_R  = (PI_Q29 + ((64'd1 << SH) >> 1)) >> SH;
    localparam logic [63:0] PI2_R = (PI_Q29 + ((64'd1 << (SH + 1)) >> 1)) >> (SH + 1);
    localparam logic signed [AW-1:0] PI_A  = AW'(PI_R);
    localparam logic signed [AW-1:0] PI2_A = AW'(PI2_R);

    // The whole pipe moves together; it holds only when the spare output entry is full.
    logic w_en;
    logic [NP-1:0] r_v;
    t_quad r_fl [NP];

    // ---------------- stage 0: magnitudes and octant ----------------
    logic [CW-1:0] w_ay, w_ax;
    logic          w_ygtx;
    logic [CW-1:0] r_pre_mn, r_pre_mx;
    logic          r_pre_z;

    // Two's complement negation keeps the most negative value exact as unsigned.
    assign w_ay   = i_y_coord[CW-1] ? (~i_y_coord + 1'b1) : i_y_coord;
    assign w_ax   = i_x_coord[CW-1] ? (~i_x_coord + 1'b1) : i_x_coord;
    assign w_ygtx = w_ay > w_ax;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pre_mx <= w_ygtx ? w_ay : w_ax;
            r_pre_mn <= w_ygtx ? w_ax : w_ay;
            r_pre_z  <= (w_ay == '0) && (w_ax == '0);
        end
    end

    // ---------------- ratio divider: r = (mn << 16) / mx ----------------
    // One quotient bit per stage, most significant first. The top bit is set
    // only when the magnitudes are equal.
    logic [CW:0]        r_d1_rem [R_WIDTH];
    logic [CW-1:0]      r_d1_mx  [R_WIDTH];
    logic [R_WIDTH-1:0] r_d1_q   [R_WIDTH];
    logic               r_d1_z   [R_WIDTH];

    for (genvar j = 0; j < R_WIDTH; j++) begin : g_d1
        logic [CW:0]        w_rem_in;
        logic [CW-1:0]      w_mx;
        logic [R_WIDTH-1:0] w_q_in;
        logic               w_z;
        logic               w_ge;
        if (j == 0) begin : g_first
            assign w_rem_in = {1'b0, r_pre_mn};
            assign w_mx     = r_pre_mx;
            assign w_q_in   = '0;
            assign w_z      = r_pre_z;
        end else begin : g_next
            assign w_rem_in = {r_d1_rem[j-1][CW-1:0], 1'b0};
            assign w_mx     = r_d1_mx[j-1];
            assign w_q_in   = r_d1_q[j-1];
            assign w_z      = r_d1_z[j-1];
        end
        assign w_ge = w_rem_in >= {1'b0, w_mx};
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d1_rem[j] <= w_ge ? (w_rem_in - {1'b0, w_mx}) : w_rem_in;
                r_d1_mx[j]  <= w_mx;
                r_d1_q[j]   <= w_q_in | (R_WIDTH'(w_ge) << (R_WIDTH - 1 - j));
                r_d1_z[j]   <= w_z;
            end
        end
    end

    // ---------------- rational polynomial, Horner form ----------------
    logic [R_WIDTH-1:0] w_r;
    logic [R_WIDTH-1:0] r_pr [4];
    logic [P_WIDTH-1:0] r_pn [4];
    logic [P_WIDTH-1:0] r_pd [4];

    // With both inputs zero the divider runs against zero; the ratio is forced to 0.
    assign w_r = r_d1_z[R_WIDTH-1] ? '0 : r_d1_q[R_WIDTH-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pr[0] <= w_r;
            r_pn[0] <= C_N4 - mul_q16(C_N5, w_r);
            r_pd[0] <= mul_q16(C_D2, w_r) + C_D1;

            r_pr[1] <= r_pr[0];
            r_pn[1] <= mul_q16(r_pn[0], r_pr[0]) + C_N3;
            r_pd[1] <= mul_q16(r_pd[0], r_pr[0]) + C_ONE;

            r_pr[2] <= r_pr[1];
            r_pn[2] <= mul_q16(r_pn[1], r_pr[1]) + C_N2;
            r_pd[2] <= r_pd[1];

            r_pr[3] <= r_pr[2];
            r_pn[3] <= mul_q16(r_pn[2], r_pr[2]) + C_N1;
            r_pd[3] <= r_pd[2];
        end
    end

    // ---------------- rounded dividend ----------------
    logic [DVW-1:0]     r_dv;
    logic [P_WIDTH-1:0] r_dd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv <= (DVW'(r_pn[3]) << F) + DVW'(r_pd[3][P_WIDTH-1:1]);
            r_dd <= r_pd[3];
        end
    end

    // ---------------- quotient divider: s = dv / den ----------------
    // The quotient never exceeds 2^F, so the bits above F of the dividend are
    // already below the denominator and seed the remainder.
    logic [P_WIDTH-1:0] r_d2_rem [QW];
    logic [P_WIDTH-1:0] r_d2_den [QW];
    logic [DVW-1:0]     r_d2_dv  [QW];
    logic [QW-1:0]      r_d2_q   [QW];

    for (genvar i = 0; i < QW; i++) begin : g_d2
        logic [P_WIDTH-1:0] w_prev;
        logic [P_WIDTH-1:0] w_den;
        logic [DVW-1:0]     w_dv;
        logic [QW-1:0]      w_q_in;
        logic [P_WIDTH:0]   w_rem_in;
        logic               w_ge;
        if (i == 0) begin : g_first
            assign w_prev = r_dv[DVW-1:F+1];
            assign w_den  = r_dd;
            assign w_dv   = r_dv;
            assign w_q_in = '0;
        end else begin : g_next
            assign w_prev = r_d2_rem[i-1];
            assign w_den  = r_d2_den[i-1];
            assign w_dv   = r_d2_dv[i-1];
            assign w_q_in = r_d2_q[i-1];
        end
        assign w_rem_in = {w_prev, w_dv[F-i]};
        assign w_ge     = w_rem_in >= {1'b0, w_den};
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d2_rem[i] <= w_ge ? P_WIDTH'(w_rem_in - {1'b0, w_den})
                                    : P_WIDTH'(w_rem_in);
                r_d2_den[i] <= w_den;
                r_d2_dv[i]  <= w_dv;
                r_d2_q[i]   <= w_q_in | (QW'(w_ge) << (F - i));
            end
        end
    end

    // ---------------- octant flags and valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fl[0] <= '{ygtx: w_ygtx, xneg: i_x_coord[CW-1], yneg: i_y_coord[CW-1]};
            for (int k = 1; k < NP; k++) begin
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NP-2:0], i_in_valid};
        end
    end

    // ---------------- quadrant fold and output buffer ----------------
    logic signed [AW-1:0] w_s0, w_s1, w_s2, w_s3;
    t_quad                w_fl;
    logic                 w_arrive;
    logic                 r_o_v, r_sk_v;
    logic [AW-1:0]        r_o_angle, r_sk_angle;

    assign w_fl = r_fl[NP-1];
    assign w_s0 = AW'(r_d2_q[QW-1]);
    assign w_s1 = w_fl.ygtx ? (PI2_A - w_s0) : w_s0;
    assign w_s2 = w_fl.xneg ? (PI_A - w_s1) : w_s1;
    assign w_s3 = w_fl.yneg ? -w_s2 : w_s2;

    assign w_en     = !r_sk_v;
    assign w_arrive = r_v[NP-1] && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (!r_o_v || !i_out_stall) begin
            r_o_v  <= r_sk_v || w_arrive;
            r_sk_v <= 1'b0;
        end else if (w_arrive) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_v || !i_out_stall) begin
            r_o_angle <= r_sk_v ? r_sk_angle : w_s3;
        end else if (w_arrive) begin
            r_sk_angle <= w_s3;
        end
    end

    assign o_in_stall  = r_sk_v;
    assign o_out_valid = r_o_v;
    assign o_angle     = r_o_angle;

    `ASSERT_PROP(a_angle_range, i_clk, i_rst_n,
        r_o_v |-> ($signed(r_o_angle) <= PI_A && $signed(r_o_angle) >= -PI_A),
        "angle outside -pi..pi")
    `ASSERT_PROP(a_ratio_range, i_clk, i_rst_n,
        r_v[ST_P] |-> (r_pr[0] <= R_WIDTH'(1 << R_FRAC)), "octant ratio above 1.0")
    `ASSERT_PROP(a_den_floor, i_clk, i_rst_n,
        r_v[ST_DF] |-> (r_dd >= C_ONE), "denominator below 1.0")
    `ASSERT_NEVER(a_skid_alone, i_clk, i_rst_n,
        r_sk_v && !r_o_v, "spare output entry full while output register empty")

endmodule
